FILE: src/stle_pkg.sv
// package: widths, modes, status codes and the queued command type
package stle_pkg;
    localparam int LOG_DEPTH = 64;
    localparam int ADDR_BITS = 10;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int LIDX_BITS = $clog2(LOG_DEPTH);
    localparam int LCNT_BITS = $clog2(LOG_DEPTH + 1);

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_LOAD   = 3'd1;
    localparam logic [2:0] MODE_STORE  = 3'd2;
    localparam logic [2:0] MODE_COMMIT = 3'd3;
    localparam logic [2:0] MODE_REMOTE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COMMIT   = 2'd1;
    localparam logic [1:0] ST_ABORT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [2:0]           mode;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          data;
    } cmd_t;

    function automatic logic [4:0] bloom_index(input logic [ADDR_BITS-1:0] w);
        logic [ADDR_BITS-1:0] x;
        x = w ^ (w >> 3);
        return x[4:0];
    endfunction
endpackage

FILE: src/stle_if.sv
// valid/ready channel interfaces for commands and results
interface stle_cmd_if;
    import stle_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           mode;
    logic [ADDR_BITS-1:0] word_address;
    logic [31:0]          write_value;
    modport source (output valid, mode, word_address, write_value, input ready);
    modport sink   (input valid, mode, word_address, write_value, output ready);
endinterface

interface stle_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  result_status;
    modport source (output valid, read_value, result_status, input ready);
    modport sink   (input valid, read_value, result_status, output ready);
endinterface

FILE: src/stle_queue.sv
// two-entry command queue between front and back
module stle_queue
    import stle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: src/stle_front.sv
// front end: accepts commands and queues them, held off while clearing
module stle_front
    import stle_pkg::*;
(
    stle_cmd_if.sink cmd,
    output logic     q_valid,
    input  logic     q_ready,
    output cmd_t     q_cmd,
    input  logic     busy
);
    // the clearing pass holds off new transfers
    assign cmd.ready   = q_ready && !busy;
    assign q_valid     = cmd.valid && !busy;
    assign q_cmd.mode  = cmd.mode;
    assign q_cmd.addr  = cmd.word_address;
    assign q_cmd.data  = cmd.write_value;
endmodule

FILE: src/stle_back.sv
// back end: sequencer over memory and logs
module stle_back
    import stle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  cmd_t      q_cmd,
    output logic      clearing,
    stle_res_if.source res
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DISP = 4'd2,
        S_WSRCH = 4'd3, S_WSRD = 4'd4, S_VAL = 4'd5, S_VRD = 4'd6, S_VCMP = 4'd7,
        S_LDRD = 4'd8, S_LDW = 4'd9, S_WBRD = 4'd10, S_WBW = 4'd11, S_OUT = 4'd12;

    logic [31:0] mem [MEM_WORDS];
    logic [ADDR_BITS+31:0] rlog [LOG_DEPTH];
    logic [ADDR_BITS+31:0] wlog [LOG_DEPTH];

    logic [3:0]           state_reg;
    cmd_t                 cur_reg;
    logic [ADDR_BITS:0]   clr_reg;
    logic [31:0]          gver_reg, snap_reg, bloom_reg;
    logic [LCNT_BITS-1:0] rcnt_reg, wcnt_reg, idx_reg;
    logic                 act_reg;
    logic [31:0]          rv_reg;
    logic [1:0]           st_reg;
    logic [31:0]          mrd_reg;
    logic [ADDR_BITS+31:0] lrd_reg;

    // memory port control (combinational request, registered read)
    logic                 m_we;
    logic [ADDR_BITS-1:0] m_addr;
    logic [31:0]          m_wd;
    logic                 rl_we, wl_we;
    logic [LIDX_BITS-1:0] rl_ra, wl_ra;

    assign clearing = (state_reg == S_CLEAR);
    assign q_ready  = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT);
    assign res.read_value = rv_reg;
    assign res.result_status = st_reg;

    always_comb
    begin
        m_we = 1'b0; m_addr = cur_reg.addr; m_wd = cur_reg.data;
        rl_we = 1'b0; wl_we = 1'b0;
        rl_ra = idx_reg[LIDX_BITS-1:0];
        wl_ra = idx_reg[LIDX_BITS-1:0];
        unique case (state_reg)
            S_CLEAR: begin m_we = 1'b1; m_addr = clr_reg[ADDR_BITS-1:0]; m_wd = '0; end
            S_DISP:  begin m_we = (cur_reg.mode == MODE_REMOTE); end
            S_VRD:   begin m_addr = lrd_reg[ADDR_BITS+31:32]; end
            S_WBW:   begin m_we = 1'b1; m_addr = lrd_reg[ADDR_BITS+31:32];
                           m_wd = lrd_reg[31:0]; end
            S_LDW:   rl_we = 1'b1;
            default: ;
        endcase
        if (state_reg == S_DISP && cur_reg.mode == MODE_STORE && act_reg
            && wcnt_reg != LCNT_BITS'(LOG_DEPTH))
            wl_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (m_we) mem[m_addr] <= m_wd;
        mrd_reg <= mem[m_addr];
        if (rl_we) rlog[rcnt_reg[LIDX_BITS-1:0]] <= {cur_reg.addr, mrd_reg};
        if (wl_we) wlog[wcnt_reg[LIDX_BITS-1:0]] <= {cur_reg.addr, cur_reg.data};
        lrd_reg <= (state_reg == S_VAL || state_reg == S_VRD) ? rlog[rl_ra] : wlog[wl_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR; clr_reg <= '0; gver_reg <= '0; snap_reg <= '0;
            bloom_reg <= '0; rcnt_reg <= '0; wcnt_reg <= '0; idx_reg <= '0;
            act_reg <= 1'b0; rv_reg <= '0; st_reg <= ST_OK; cur_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (ADDR_BITS+1)'(MEM_WORDS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (q_valid)
                    begin
                        cur_reg <= q_cmd; rv_reg <= '0; st_reg <= ST_OK;
                        state_reg <= S_DISP;
                    end
                S_DISP:
                begin
                    state_reg <= S_OUT;
                    priority case (1'b1)
                        (cur_reg.mode == MODE_START):
                        begin
                            rcnt_reg <= '0; wcnt_reg <= '0; bloom_reg <= '0;
                            snap_reg <= gver_reg; act_reg <= 1'b1;
                        end
                        (cur_reg.mode == MODE_REMOTE): gver_reg <= gver_reg + 32'd2;
                        (cur_reg.mode > MODE_REMOTE): ;
                        (!act_reg): st_reg <= ST_ABORT;
                        (cur_reg.mode == MODE_STORE):
                            if (wcnt_reg == LCNT_BITS'(LOG_DEPTH))
                            begin
                                act_reg <= 1'b0; st_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                bloom_reg[bloom_index(cur_reg.addr)] <= 1'b1;
                                wcnt_reg <= wcnt_reg + 1'b1;
                            end
                        (cur_reg.mode == MODE_LOAD):
                            if (bloom_reg[bloom_index(cur_reg.addr)] && wcnt_reg != 0)
                            begin
                                idx_reg <= wcnt_reg - 1'b1; state_reg <= S_WSRCH;
                            end
                            else
                            begin
                                idx_reg <= '0; state_reg <= S_VAL;
                            end
                        default: // commit
                            if (wcnt_reg == 0)
                            begin
                                rcnt_reg <= '0; bloom_reg <= '0; act_reg <= 1'b0;
                                st_reg <= ST_COMMIT;
                            end
                            else
                            begin
                                idx_reg <= '0; state_reg <= S_VAL;
                            end
                    endcase
                end
                S_WSRCH: state_reg <= S_WSRD;
                S_WSRD:
                    if (lrd_reg[ADDR_BITS+31:32] == cur_reg.addr)
                    begin
                        rv_reg <= lrd_reg[31:0]; state_reg <= S_OUT;
                    end
                    else if (idx_reg == 0)
                        state_reg <= S_VAL;
                    else
                    begin
                        idx_reg <= idx_reg - 1'b1; state_reg <= S_WSRCH;
                    end
                S_VAL:
                    if (gver_reg == snap_reg || idx_reg == rcnt_reg)
                    begin
                        snap_reg <= gver_reg; idx_reg <= '0;
                        if (cur_reg.mode == MODE_LOAD)
                            if (rcnt_reg == LCNT_BITS'(LOG_DEPTH))
                            begin
                                act_reg <= 1'b0; st_reg <= ST_OVERFLOW; state_reg <= S_OUT;
                            end
                            else state_reg <= S_LDRD;
                        else state_reg <= S_WBRD;
                    end
                    else state_reg <= S_VRD;
                S_VRD: state_reg <= S_VCMP;
                S_VCMP:
                    if (mrd_reg != lrd_reg[31:0])
                    begin
                        act_reg <= 1'b0; st_reg <= ST_ABORT; state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1; state_reg <= S_VAL;
                    end
                S_LDRD: state_reg <= S_LDW;
                S_LDW:
                begin
                    rv_reg <= mrd_reg; rcnt_reg <= rcnt_reg + 1'b1; state_reg <= S_OUT;
                end
                S_WBRD:
                    if (idx_reg == wcnt_reg)
                    begin
                        gver_reg <= snap_reg + 32'd2; rcnt_reg <= '0; wcnt_reg <= '0;
                        bloom_reg <= '0; act_reg <= 1'b0; st_reg <= ST_COMMIT;
                        state_reg <= S_OUT;
                    end
                    else state_reg <= S_WBW;
                S_WBW:
                begin
                    idx_reg <= idx_reg + 1'b1; state_reg <= S_WBRD;
                end
                S_OUT: if (res.ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/stm_transaction_log_engine.sv
// top level: transactional memory engine with front end, queue and back end
// After reset the block clears its 1024-word memory, one word a cycle,
// before the first command transfer. Start, store and remote write go
// straight from dispatch to the result; a load that hits the write log
// walks it newest first; a load or commit that sees the version moved
// checks each read-log entry against memory in turn; commit write-back
// copies each write-log entry to memory. The back-end sequencer takes
// these steps over the single memory port; a two-entry queue lets commands
// arrive while the back end works; a result waits in an output register.
module stm_transaction_log_engine
    import stle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    stle_cmd_if.sink    cmd,
    stle_res_if.source  res
);
    logic f_valid, f_ready, b_valid, b_ready, clearing;
    cmd_t f_cmd, b_cmd;

    // front end accepts and forwards commands
    stle_front u_front (.cmd(cmd), .q_valid(f_valid), .q_ready(f_ready),
        .q_cmd(f_cmd), .busy(clearing));

    // decoupling queue
    stle_queue u_queue (.clk(clk), .rst_n(rst_n), .in_valid(f_valid),
        .in_ready(f_ready), .in_cmd(f_cmd), .out_valid(b_valid),
        .out_ready(b_ready), .out_cmd(b_cmd));

    // back end carries out commands
    stle_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(b_valid),
        .q_ready(b_ready), .q_cmd(b_cmd), .clearing(clearing), .res(res));
endmodule

FILE: src/stle_checker.sv
// port-level checker bound to the top level
module stle_checker
    import stle_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_read_value,
    input logic [1:0]  res_result_status
);
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_read_value))
        else $error("result dropped while stalled");
    a_commit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_result_status == ST_COMMIT |-> res_read_value == 32'd0)
        else $error("commit carries data");
    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_result_status != ST_OK |-> res_read_value == 32'd0)
        else $error("failed op carries data");
endmodule

bind stm_transaction_log_engine stle_checker u_chk (.clk(clk), .rst_n(rst_n),
    .res_valid(res.valid), .res_ready(res.ready), .res_read_value(res.read_value),
    .res_result_status(res.result_status));

FILE: tb/tb_stle_if_note.sv
// testbench helper package: command and result item types used by the stimulus and expected-result queues
package tb_stle_pkg;
    import stle_pkg::*;
    typedef struct {
        logic [2:0]           mode;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          data;
    } tb_cmd_t;
    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } tb_res_t;
endpackage

FILE: tb/tb_stm_transaction_log_engine.sv
// testbench top: drives directed and random transactions and checks every result transfer
module tb_stm_transaction_log_engine;
    import stle_pkg::*;
    import tb_stle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2000;

    logic clk;
    logic rst_n;

    stle_cmd_if cmd ();
    stle_res_if res ();

    stm_transaction_log_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    // clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow of the engine state, updated in transfer order
    logic [31:0]          mem_shadow [MEM_WORDS];
    logic [31:0]          version;
    logic [31:0]          snapshot;
    logic [ADDR_BITS-1:0] rlog_addr [LOG_DEPTH];
    logic [31:0]          rlog_val  [LOG_DEPTH];
    logic [ADDR_BITS-1:0] wlog_addr [LOG_DEPTH];
    logic [31:0]          wlog_val  [LOG_DEPTH];
    int                   rcount;
    int                   wcount;
    logic [31:0]          bloom;
    logic                 active;

    tb_cmd_t pending_cmds [$];
    tb_res_t expected_results [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stim_done = 0;
    bit  no_idle = 0;
    bit  hold_off = 0;

    function automatic logic [31:0] bloom_of(input logic [ADDR_BITS-1:0] w);
        logic [ADDR_BITS-1:0] x;
        x = w ^ (w >> 3);
        return 32'd1 << x[4:0];
    endfunction

    // every logged read still matches the shadow memory
    function automatic bit reads_still_valid();
        for (int i = 0; i < rcount; i++)
            if (mem_shadow[rlog_addr[i]] != rlog_val[i])
                return 0;
        return 1;
    endfunction

    // predicts one result and advances the shadow state
    function automatic tb_res_t predict_txn(input tb_cmd_t c);
        tb_res_t r;
        bit      hit;
        r.value = '0;
        r.status = ST_OK;
        hit = 0;
        case (c.mode)
            MODE_START:
            begin
                rcount = 0;
                wcount = 0;
                bloom = '0;
                snapshot = version;
                active = 1;
            end
            MODE_LOAD:
            begin
                if (!active)
                    r.status = ST_ABORT;
                else
                begin
                    if ((bloom & bloom_of(c.addr)) != 0)
                        for (int i = wcount - 1; i >= 0; i--)
                            if (!hit && wlog_addr[i] == c.addr)
                            begin
                                r.value = wlog_val[i];
                                hit = 1;
                            end
                    if (!hit)
                    begin
                        if (version != snapshot && !reads_still_valid())
                        begin
                            active = 0;
                            r.status = ST_ABORT;
                        end
                        else
                        begin
                            snapshot = version;
                            if (rcount >= LOG_DEPTH)
                            begin
                                active = 0;
                                r.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                r.value = mem_shadow[c.addr];
                                rlog_addr[rcount] = c.addr;
                                rlog_val[rcount] = r.value;
                                rcount++;
                            end
                        end
                    end
                end
            end
            MODE_STORE:
            begin
                if (!active)
                    r.status = ST_ABORT;
                else if (wcount >= LOG_DEPTH)
                begin
                    active = 0;
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    bloom |= bloom_of(c.addr);
                    wlog_addr[wcount] = c.addr;
                    wlog_val[wcount] = c.data;
                    wcount++;
                end
            end
            MODE_COMMIT:
            begin
                if (!active)
                    r.status = ST_ABORT;
                else if (wcount != 0 && version != snapshot && !reads_still_valid())
                begin
                    active = 0;
                    r.status = ST_ABORT;
                end
                else
                begin
                    if (wcount != 0)
                    begin
                        snapshot = version;
                        for (int i = 0; i < wcount; i++)
                            mem_shadow[wlog_addr[i]] = wlog_val[i];
                        version = snapshot + 32'd2;
                    end
                    rcount = 0;
                    wcount = 0;
                    bloom = '0;
                    active = 0;
                    r.status = ST_COMMIT;
                end
            end
            MODE_REMOTE:
            begin
                mem_shadow[c.addr] = c.data;
                version = version + 32'd2;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic tb_cmd_t make_cmd(input logic [2:0] m, input logic [ADDR_BITS-1:0] a,
                                         input logic [31:0] d);
        tb_cmd_t c;
        c.mode = m;
        c.addr = a;
        c.data = d;
        return c;
    endfunction

    // small address pool makes conflicts, Bloom hits and aliasing common
    function automatic logic [ADDR_BITS-1:0] pick_addr();
        if ($urandom_range(0, 3) != 0)
            return ADDR_BITS'($urandom_range(0, 15));
        return ADDR_BITS'($urandom);
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one random transaction: start, a body of loads, stores and other modes, usually a commit
    task automatic push_random_txn();
        int n;
        int k;
        pending_cmds.push_back(make_cmd(MODE_START, pick_addr(), pick_data()));
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
                pending_cmds.push_back(make_cmd(MODE_LOAD, pick_addr(), pick_data()));
            else if (k < 8)
                pending_cmds.push_back(make_cmd(MODE_STORE, pick_addr(), pick_data()));
            else if (k == 8)
                pending_cmds.push_back(make_cmd(MODE_REMOTE, pick_addr(), pick_data()));
            else
                pending_cmds.push_back(make_cmd(3'($urandom_range(0, 7)), pick_addr(),
                                                pick_data()));
        end
        if ($urandom_range(0, 9) != 0)
            pending_cmds.push_back(make_cmd(MODE_COMMIT, pick_addr(), pick_data()));
    endtask

    // fills the stimulus queue
    initial
    begin
        // directed: not active ops, empty commit, unknown modes, Bloom hit, conflicts
        pending_cmds.push_back(make_cmd(MODE_LOAD, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_STORE, '1, '1));
        pending_cmds.push_back(make_cmd(MODE_COMMIT, '0, '0));
        pending_cmds.push_back(make_cmd(3'd5, '1, '1));
        pending_cmds.push_back(make_cmd(3'd6, '0, '0));
        pending_cmds.push_back(make_cmd(3'd7, '1, '1));
        pending_cmds.push_back(make_cmd(MODE_START, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_COMMIT, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_START, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_LOAD, '1, '0));
        pending_cmds.push_back(make_cmd(MODE_STORE, '1, 32'hFFFF_FFFF));
        pending_cmds.push_back(make_cmd(MODE_STORE, 10'd8, 32'h1234_5678));
        pending_cmds.push_back(make_cmd(MODE_LOAD, '1, '0));
        pending_cmds.push_back(make_cmd(MODE_LOAD, 10'd0, '0));
        pending_cmds.push_back(make_cmd(MODE_REMOTE, 10'd5, 32'hA5A5_A5A5));
        pending_cmds.push_back(make_cmd(MODE_LOAD, 10'd7, '0));
        pending_cmds.push_back(make_cmd(MODE_COMMIT, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_START, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_LOAD, '1, '0));
        pending_cmds.push_back(make_cmd(MODE_STORE, 10'd3, 32'h5));
        pending_cmds.push_back(make_cmd(MODE_REMOTE, '1, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_COMMIT, '0, '0));
        pending_cmds.push_back(make_cmd(MODE_START, '0, '0));
        // write-log overflow, then read-log overflow
        for (int i = 0; i <= LOG_DEPTH; i++)
            pending_cmds.push_back(make_cmd(MODE_STORE, ADDR_BITS'(i), $urandom));
        pending_cmds.push_back(make_cmd(MODE_START, '0, '0));
        for (int i = 0; i <= LOG_DEPTH; i++)
            pending_cmds.push_back(make_cmd(MODE_LOAD, ADDR_BITS'(i), '0));
        while (pending_cmds.size() < 2200)
            push_random_txn();
    end

    // driver: offers queued commands, idles about a third of the time outside the no-idle stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.mode <= '0;
            cmd.word_address <= '0;
            cmd.write_value <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                expected_results.push_back(predict_txn(make_cmd(cmd.mode, cmd.word_address,
                                                                cmd.write_value)));
                void'(pending_cmds.pop_front());
            end
            if (!cmd.valid || cmd.ready)
            begin
                if ((cmd.valid && cmd.ready ? pending_cmds.size() > 0 : pending_cmds.size() > 0)
                    && (no_idle || $urandom_range(0, 99) >= 33))
                begin
                    cmd.valid <= 1'b1;
                    cmd.mode <= pending_cmds[0].mode;
                    cmd.word_address <= pending_cmds[0].addr;
                    cmd.write_value <= pending_cmds[0].data;
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // monitor: random backpressure, compares each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %h status %0d",
                                 res.read_value, res.result_status);
                end
                else
                begin
                    if (res.read_value !== expected_results[0].value
                        || res.result_status !== expected_results[0].status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %h status %0d, got %h %0d",
                                     expected_results[0].value, expected_results[0].status,
                                     res.read_value, res.result_status);
                    end
                    void'(expected_results.pop_front());
                end
            end
            res.ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 33);
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n && ((cmd.valid && cmd.ready) || (res.valid && res.ready)))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stm_transaction_log_engine verification failed");
            $finish;
        end
    end

    // reset, pressure phases and end of run
    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
            mem_shadow[i] = '0;
        version = '0;
        snapshot = '0;
        rcount = 0;
        wcount = 0;
        bloom = '0;
        active = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // receiver holds off while the sender keeps offering
        wait (pending_cmds.size() < 2000);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
        // stretch with no idling on either side
        wait (pending_cmds.size() < 1200);
        no_idle = 1;
        wait (pending_cmds.size() < 800);
        no_idle = 0;
        wait (pending_cmds.size() == 0 && !cmd.valid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("stm_transaction_log_engine verification clean");
        else
            $display("stm_transaction_log_engine verification failed");
        $finish;
    end
endmodule

FILE: stm_transaction_log_engine.f
src/stle_pkg.sv
src/stle_if.sv
src/stle_queue.sv
src/stle_front.sv
src/stle_back.sv
src/stm_transaction_log_engine.sv
src/stle_checker.sv
tb/tb_stle_if_note.sv
tb/tb_stm_transaction_log_engine.sv
